FILE: rtl/tracked_object_stillness_detector_macros.svh
// assertion macros for the stillness detector
// used by rtl modules that carry concurrent checks; needs nothing else
`ifndef TRACKED_OBJECT_STILLNESS_DETECTOR_MACROS_SVH
`define TRACKED_OBJECT_STILLNESS_DETECTOR_MACROS_SVH

// same-cycle implication, switched off during reset
`define TOSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off during reset
`define TOSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tosd_pkg.sv
// shared types and constants for the tracked object stillness detector
// no dependencies
package tosd_pkg;

  localparam int BLOB_SLOTS_DEF = 64;

  localparam logic OP_BLOB = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [1:0] MS_NONE   = 2'd0;
  localparam logic [1:0] MS_MOTION = 2'd1;
  localparam logic [1:0] MS_STILL  = 2'd2;

  // ascii 'a', codes for the other states follow it
  localparam logic [7:0] CODE_A = 8'h61;

  localparam logic [19:0] DIST_SQ_RST  = 20'd10;
  localparam logic [15:0] DWELL_RST    = 16'd2000;
  localparam logic [15:0] INTERVAL_RST = 16'd100;
  localparam logic        SERIAL_RST   = 1'b0;

  typedef enum logic [1:0] {
    REG_DIST_SQ  = 2'd0,
    REG_DWELL    = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_SERIAL   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        op;
    logic [5:0]  blob_id;
    logic [15:0] centroid_x;
    logic [15:0] centroid_y;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motion_state;
    logic       send_valid;
    logic [7:0] code_byte;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] stamp;
  } slot_entry_t;

  // what the decision stage hands to the frame reporter
  typedef struct packed {
    logic        obs;
    logic        moving;
    logic        eof;
    logic [31:0] now_ms;
  } frame_evt_t;

endpackage

FILE: rtl/tosd_slot_table.sv
// per-blob cache: centroid and time stamp memory plus entry valid flags
// depends on tosd_pkg
module tosd_slot_table #(
  parameter int BLOB_SLOTS = tosd_pkg::BLOB_SLOTS_DEF,
  parameter int SLOT_W     = (BLOB_SLOTS > 1) ? $clog2(BLOB_SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [SLOT_W-1:0]      rd_idx,
  output tosd_pkg::slot_entry_t  rd_data,
  input  logic [SLOT_W-1:0]      vld_idx,
  output logic                   vld_out,
  input  logic                   wr_en,
  input  logic [SLOT_W-1:0]      wr_idx,
  input  tosd_pkg::slot_entry_t  wr_data
);
  import tosd_pkg::*;

  slot_entry_t              mem [BLOB_SLOTS];
  slot_entry_t              rd_data_r;
  logic [BLOB_SLOTS-1:0]    valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign vld_out = valid_r[vld_idx];

endmodule

FILE: rtl/tosd_frame_report.sv
// per-frame flags, send interval timing and the result register
// depends on tosd_pkg and the assertion macro header
`include "tracked_object_stillness_detector_macros.svh"

module tosd_frame_report (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tosd_pkg::frame_evt_t  evt,
  input  logic [15:0]           send_interval,
  input  logic                  serial_en,
  output logic                  blocked,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tosd_pkg::out_item_t   out_data
);
  import tosd_pkg::*;

  logic        has_blobs_r, has_blobs_nxt;
  logic        any_moving_r, any_moving_nxt;
  logic [31:0] last_send_r, last_send_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic        fire;
  logic        send_due;
  logic [31:0] since_send;
  logic [1:0]  state;

  // an end of frame waits while the result register is full and stalled
  assign blocked    = evt.eof && out_valid_r && out_stall;
  assign fire       = evt.eof && !blocked;
  assign since_send = evt.now_ms - last_send_r;
  assign send_due   = since_send > {16'd0, send_interval};

  always_comb begin
    if (!has_blobs_r) begin
      state = MS_NONE;
    end else if (any_moving_r) begin
      state = MS_MOTION;
    end else begin
      state = MS_STILL;
    end
  end

  always_comb begin
    has_blobs_nxt  = has_blobs_r;
    any_moving_nxt = any_moving_r;
    last_send_nxt  = last_send_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    if (fire) begin
      has_blobs_nxt        = 1'b0;
      any_moving_nxt       = 1'b0;
      out_valid_nxt        = 1'b1;
      out_nxt.motion_state = state;
      out_nxt.send_valid   = send_due && serial_en;
      out_nxt.code_byte    = CODE_A + {6'd0, state};
      if (send_due) begin
        last_send_nxt = evt.now_ms;
      end
    end else if (evt.obs) begin
      has_blobs_nxt = 1'b1;
      if (evt.moving) begin
        any_moving_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_blobs_r  <= 1'b0;
      any_moving_r <= 1'b0;
      last_send_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      has_blobs_r  <= has_blobs_nxt;
      any_moving_r <= any_moving_nxt;
      last_send_r  <= last_send_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TOSD_ASSERT_IMP(a_code_matches_state, clk, rst_n, out_valid_r, out_r.code_byte == (CODE_A + {6'd0, out_r.motion_state}), "code byte does not match motion state")
  `TOSD_ASSERT_NXT(a_flags_clear_after_eof, clk, rst_n, fire, !has_blobs_r && !any_moving_r, "frame flags not cleared after end of frame")
  `TOSD_ASSERT_NXT(a_send_time_taken, clk, rst_n, fire && send_due, last_send_r == $past(evt.now_ms), "send time not updated when interval elapsed")

endmodule

FILE: rtl/tracked_object_stillness_detector.sv
// Tracked object stillness detector. Takes one transfer per cycle: blob
// observations and end-of-frame markers. Each item passes three registers
// (table read, squared distance and elapsed time, decision and table write),
// so an end-of-frame result is registered once its marker leaves the second.
// Throughput is one item per cycle unless stalled, set by the single read
// and single write port of the blob table; back-to-back observations of the
// same id are forwarded around the table. The input stalls only while an
// end-of-frame marker reaches the decision stage with the result register
// full and stalled. The table comes out of reset empty with no clearing pass.
module tracked_object_stillness_detector #(
  parameter int BLOB_SLOTS = tosd_pkg::BLOB_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tosd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tosd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tosd_pkg::cfg_reg_t   cfg_index,
  input  logic [19:0]          cfg_data
);
  import tosd_pkg::*;

  localparam int SLOT_W = (BLOB_SLOTS > 1) ? $clog2(BLOB_SLOTS) : 1;

  // configuration
  logic [19:0] dist_sq_r;
  logic [15:0] dwell_r;
  logic [15:0] interval_r;
  logic        serial_r;

  // handshake
  logic accept;
  logic adv;
  logic blocked;

  // first stage: item and table read
  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              s1_hit_r;
  logic [SLOT_W-1:0] s1_idx_r;
  logic              s1_byp_r;
  slot_entry_t       s1_byp_data_r;
  slot_entry_t       rd_data;
  logic              vld_out;
  logic              s1_fwd;
  slot_entry_t       s1_cached;
  logic              s1_known;
  logic signed [16:0] s1_dx, s1_dy;
  logic signed [33:0] s1_dx_sq, s1_dy_sq;

  // second stage: decision
  logic              s2_valid_r;
  logic              s2_eof_r;
  logic              s2_hit_r;
  logic              s2_known_r;
  logic [SLOT_W-1:0] s2_idx_r;
  logic [31:0]       s2_sqx_r, s2_sqy_r;
  logic [31:0]       s2_elapsed_r;
  logic [15:0]       s2_x_r, s2_y_r;
  logic [31:0]       s2_now_r;
  logic [32:0]       s2_dsq;
  logic              s2_below, s2_above, s2_dwelt, s2_still;

  logic              wr_en;
  slot_entry_t       wr_data;
  frame_evt_t        evt;
  logic              in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_sq_r  <= DIST_SQ_RST;
      dwell_r    <= DWELL_RST;
      interval_r <= INTERVAL_RST;
      serial_r   <= SERIAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIST_SQ:  dist_sq_r  <= cfg_data;
        REG_DWELL:    dwell_r    <= cfg_data[15:0];
        REG_INTERVAL: interval_r <= cfg_data[15:0];
        REG_SERIAL:   serial_r   <= cfg_data[0];
        default:      dist_sq_r  <= dist_sq_r;
      endcase
    end
  end

  assign adv      = !blocked;
  assign in_stall = blocked;
  assign accept   = in_valid && adv;
  assign in_range = 32'(in_data.blob_id) < BLOB_SLOTS;

  tosd_slot_table #(
    .BLOB_SLOTS (BLOB_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (SLOT_W'(in_data.blob_id)),
    .rd_data (rd_data),
    .vld_idx (s1_idx_r),
    .vld_out (vld_out),
    .wr_en   (wr_en),
    .wr_idx  (s2_idx_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  // the read at this edge misses a write at the same edge, so keep that write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r     <= in_data;
      s1_hit_r      <= (in_data.op == OP_BLOB) && in_range;
      s1_idx_r      <= SLOT_W'(in_data.blob_id);
      s1_byp_r      <= wr_en && (s2_idx_r == SLOT_W'(in_data.blob_id));
      s1_byp_data_r <= wr_data;
    end
  end

  // forward the write that the decision stage makes this cycle
  assign s1_fwd    = wr_en && (s2_idx_r == s1_idx_r);
  assign s1_cached = s1_fwd   ? wr_data :
                     s1_byp_r ? s1_byp_data_r : rd_data;
  assign s1_known  = vld_out || s1_fwd;

  assign s1_dx    = $signed({1'b0, s1_item_r.centroid_x}) - $signed({1'b0, s1_cached.x});
  assign s1_dy    = $signed({1'b0, s1_item_r.centroid_y}) - $signed({1'b0, s1_cached.y});
  assign s1_dx_sq = s1_dx * s1_dx;
  assign s1_dy_sq = s1_dy * s1_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_eof_r     <= s1_item_r.op == OP_EOF;
      s2_hit_r     <= s1_hit_r;
      s2_known_r   <= s1_known;
      s2_idx_r     <= s1_idx_r;
      s2_sqx_r     <= s1_dx_sq[31:0];
      s2_sqy_r     <= s1_dy_sq[31:0];
      s2_elapsed_r <= s1_item_r.now_ms - s1_cached.stamp;
      s2_x_r       <= s1_item_r.centroid_x;
      s2_y_r       <= s1_item_r.centroid_y;
      s2_now_r     <= s1_item_r.now_ms;
    end
  end

  assign s2_dsq   = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
  assign s2_below = s2_dsq < {13'd0, dist_sq_r};
  assign s2_above = s2_dsq > {13'd0, dist_sq_r};
  assign s2_dwelt = s2_elapsed_r > {16'd0, dwell_r};
  assign s2_still = s2_known_r && s2_below && s2_dwelt;

  // new ids are cached, known ones only when they moved past the threshold
  assign wr_en = s2_valid_r && !s2_eof_r && s2_hit_r && (!s2_known_r || s2_above);
  assign wr_data.x     = s2_x_r;
  assign wr_data.y     = s2_y_r;
  assign wr_data.stamp = s2_now_r;

  assign evt.obs    = s2_valid_r && !s2_eof_r && s2_hit_r;
  assign evt.moving = s2_known_r && !s2_still;
  assign evt.eof    = s2_valid_r && s2_eof_r;
  assign evt.now_ms = s2_now_r;

  tosd_frame_report u_report (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt           (evt),
    .send_interval (interval_r),
    .serial_en     (serial_r),
    .blocked       (blocked),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

FILE: sim/tracked_object_stillness_detector_test.sv
`timescale 1ns / 1ps
// testbench for the tracked object stillness detector: directed frames, then random frames
// checked against an in-bench model of the blob table; needs rtl/tosd_pkg.sv and the top level
module tracked_object_stillness_detector_test;
  import tosd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // model of the blob table and frame reporter, plus the queue of frame reports still due
  class frame_scoreboard;
    logic [19:0] dist_limit;
    logic [15:0] dwell;
    logic [15:0] interval;
    logic        serial_on;
    bit          slot_live [BLOB_SLOTS_DEF];
    logic [15:0] slot_x [BLOB_SLOTS_DEF];
    logic [15:0] slot_y [BLOB_SLOTS_DEF];
    logic [31:0] slot_stamp [BLOB_SLOTS_DEF];
    bit          saw_blob;
    bit          saw_motion;
    logic [31:0] last_send;
    out_item_t   pending_reports [$];
    int          mismatches;

    function new();
      dist_limit = DIST_SQ_RST;
      dwell = DWELL_RST;
      interval = INTERVAL_RST;
      serial_on = SERIAL_RST;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      saw_blob = 1'b0;
      saw_motion = 1'b0;
      last_send = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [19:0] v);
      case (idx)
        REG_DIST_SQ:  dist_limit = v;
        REG_DWELL:    dwell = v[15:0];
        REG_INTERVAL: interval = v[15:0];
        REG_SERIAL:   serial_on = v[0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      longint dx;
      longint dy;
      longint dsq;
      logic [31:0] age;
      logic [31:0] since_send;
      out_item_t rep;
      if (it.op == OP_BLOB) begin
        saw_blob = 1'b1;
        if (!slot_live[it.blob_id]) begin
          slot_live[it.blob_id] = 1'b1;
          slot_x[it.blob_id] = it.centroid_x;
          slot_y[it.blob_id] = it.centroid_y;
          slot_stamp[it.blob_id] = it.now_ms;
        end else begin
          dx = longint'(it.centroid_x) - longint'(slot_x[it.blob_id]);
          dy = longint'(it.centroid_y) - longint'(slot_y[it.blob_id]);
          dsq = dx * dx + dy * dy;
          age = it.now_ms - slot_stamp[it.blob_id];
          if (!(dsq < longint'(dist_limit) && age > {16'd0, dwell})) begin
            saw_motion = 1'b1;
            // equal to the threshold counts as moving but keeps the old anchor
            if (dsq > longint'(dist_limit)) begin
              slot_x[it.blob_id] = it.centroid_x;
              slot_y[it.blob_id] = it.centroid_y;
              slot_stamp[it.blob_id] = it.now_ms;
            end
          end
        end
      end else begin
        if (!saw_blob) rep.motion_state = MS_NONE;
        else if (saw_motion) rep.motion_state = MS_MOTION;
        else rep.motion_state = MS_STILL;
        rep.send_valid = 1'b0;
        since_send = it.now_ms - last_send;
        // the send time moves on even with the serial link off
        if (since_send > {16'd0, interval}) begin
          last_send = it.now_ms;
          rep.send_valid = serial_on;
        end
        rep.code_byte = CODE_A + 8'(rep.motion_state);
        saw_blob = 1'b0;
        saw_motion = 1'b0;
        pending_reports.push_back(rep);
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch("frame report with none due");
      end else begin
        want = pending_reports.pop_front();
        if (got.motion_state !== want.motion_state)
          report_mismatch($sformatf("motion_state %0d, want %0d",
                                    got.motion_state, want.motion_state));
        if (got.send_valid !== want.send_valid)
          report_mismatch($sformatf("send_valid %0b, want %0b",
                                    got.send_valid, want.send_valid));
        if (got.code_byte !== want.code_byte)
          report_mismatch($sformatf("code_byte %h, want %h",
                                    got.code_byte, want.code_byte));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_reg_t  cfg_index = REG_DIST_SQ;
  logic [19:0] cfg_data = '0;

  frame_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // generator state: where each id currently sits and the running frame clock
  logic [15:0] spot_x [BLOB_SLOTS_DEF];
  logic [15:0] spot_y [BLOB_SLOTS_DEF];
  int          pool [6];
  logic [31:0] frame_ms;
  int          reach;

  tracked_object_stillness_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_item(logic op, logic [5:0] id, logic [15:0] x,
                                       logic [15:0] y, logic [31:0] t);
    in_item_t it;
    it.op = op;
    it.blob_id = id;
    it.centroid_x = x;
    it.centroid_y = y;
    it.now_ms = t;
    return it;
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] p, int span);
    return p + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  // valid stays up between back-to-back transfers; a gap drops it first
  task drive_item(in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task put_reg(cfg_reg_t idx, logic [19:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task write_config(logic [19:0] th, logic [15:0] dw, logic [15:0] iv, logic se);
    put_reg(REG_DIST_SQ, th);
    put_reg(REG_DWELL, {4'd0, dw});
    put_reg(REG_INTERVAL, {4'd0, iv});
    put_reg(REG_SERIAL, {19'd0, se});
    cfg_valid <= 1'b0;
    reach = 1;
    while (reach * reach * 2 < int'(th) && reach < 1000) reach++;
  endtask

  // observations give no report, so allow for ones still inside the pipe
  task wait_drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task run_random(int budget);
    int count;
    int n;
    int pick;
    int kind;
    in_item_t it;
    foreach (pool[i]) pool[i] = $urandom_range(0, BLOB_SLOTS_DEF - 1);
    count = 0;
    while (count < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: any field value at all
        it = mk_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), 16'($urandom),
                     16'($urandom), $urandom);
        drive_item(it);
        count++;
      end else begin
        if ($urandom_range(0, 99) < 5) frame_ms = $urandom;
        else frame_ms += $urandom_range(0, sb.dwell / 3 + sb.interval / 2 + 20);
        n = $urandom_range(0, 4);
        repeat (n) begin
          pick = pool[$urandom_range(0, 5)];
          kind = $urandom_range(0, 99);
          if (kind < 40) begin
          end else if (kind < 65) begin
            spot_x[pick] = nudge(spot_x[pick], 1);
            spot_y[pick] = nudge(spot_y[pick], 1);
          end else if (kind < 85) begin
            spot_x[pick] = nudge(spot_x[pick], reach + 1);
            spot_y[pick] = nudge(spot_y[pick], reach + 1);
          end else if (kind < 97) begin
            spot_x[pick] = nudge(spot_x[pick], 3000);
            spot_y[pick] = nudge(spot_y[pick], 3000);
          end else begin
            spot_x[pick] = 16'($urandom);
            spot_y[pick] = 16'($urandom);
          end
          drive_item(mk_item(OP_BLOB, 6'(pick), spot_x[pick], spot_y[pick], frame_ms));
          count++;
        end
        drive_item(mk_item(OP_EOF, 6'($urandom_range(0, 63)), 16'($urandom), 16'($urandom),
                           frame_ms));
        count++;
      end
    end
  endtask

  initial begin
    sb = new();
    foreach (spot_x[i]) begin
      spot_x[i] = 16'($urandom);
      spot_y[i] = 16'($urandom);
    end
    frame_ms = $urandom;
    reach = 3;
    send_idle_pct = 34;
    recv_idle_pct = 49;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at reset settings
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'd0));
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0000, 16'h0000, 32'd50));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'd50));
    // known id not yet dwelt long enough
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0000, 16'h0000, 32'd1000));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'd1000));
    // distance exactly on the threshold, then just under it, same id twice in a frame
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0001, 16'h0003, 32'd2100));
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0003, 16'h0000, 32'd2100));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'd2100));
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0000, 16'h0000, 32'd2100));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'd2101));
    // largest jump across the table's last slot
    drive_item(mk_item(OP_BLOB, 6'd63, 16'hFFFF, 16'hFFFF, 32'd2200));
    drive_item(mk_item(OP_BLOB, 6'd63, 16'h0000, 16'h0000, 32'd2200));
    drive_item(mk_item(OP_BLOB, 6'd63, 16'h0000, 16'h0000, 32'd2201));
    drive_item(mk_item(OP_EOF, 6'd63, 16'hFFFF, 16'hFFFF, 32'd2201));
    // dwell and send interval measured across the wrap of the ms counter
    drive_item(mk_item(OP_BLOB, 6'd42, 16'hAAAA, 16'h5555, 32'hFFFF_FF00));
    drive_item(mk_item(OP_EOF, 6'd42, 16'hAAAA, 16'h5555, 32'hFFFF_FF00));
    drive_item(mk_item(OP_BLOB, 6'd42, 16'hAAAA, 16'h5555, 32'h0000_0800));
    drive_item(mk_item(OP_BLOB, 6'd21, 16'h5555, 16'hAAAA, 32'h0000_0800));
    drive_item(mk_item(OP_EOF, 6'd21, 16'h5555, 16'hAAAA, 32'h0000_0800));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'h0000_0801));
    drive_item(mk_item(OP_BLOB, 6'd0, 16'h0000, 16'h0000, 32'h7FFF_FFFF));
    drive_item(mk_item(OP_EOF, 6'd0, 16'h0000, 16'h0000, 32'h8000_0000));
    wait_drain();

    write_config(20'd10, 16'd2000, 16'd100, 1'b1);
    run_random(100);
    wait_drain();
    write_config(20'd0, 16'd0, 16'd0, 1'b1);
    run_random(100);
    wait_drain();

    send_idle_pct = 49;
    recv_idle_pct = 34;
    write_config(20'hFFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_random(100);
    wait_drain();
    write_config(20'($urandom_range(0, 5000)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 500)), 1'b0);
    run_random(100);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(20'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    run_random(100);
    wait_drain();
    write_config(20'd25, 16'd500, 16'd50, 1'b1);
    run_random(100);
    wait_drain();

    if (sb.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
